// ===== design/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

   // Fixed field widths of the request and response channels.
   localparam int ROW_W     = 4;
   localparam int VALUE_W   = 16;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int PRODUCT_W = 36;
   localparam int DIM_W     = 5;
   localparam int REQ_W     = 2;
   localparam int CSR_IDX_W = 2;

   // Request type codes.
   localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   // Reset value of every dimension register.
   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   // Response status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // Command queue between the front and the back end (power-of-two depth).
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Classified operation carried through the queue.
   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_READ    = 2'd2,
      OP_ERROR   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [ROW_W-1:0]           row;
      logic [ROW_W-1:0]           col;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   // Effective (clamped) dimensions.
   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } dims_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/mme_front.sv =====
// Front end: accepts requests, range-checks them and queues a classified command.
module mme_front (
   input  logic                                    start,
   output logic                                    busy,
   input  logic [mme_pkg::REQ_W-1:0]               req_type,
   input  logic [mme_pkg::ROW_W-1:0]               req_row_index,
   input  logic [mme_pkg::ROW_W-1:0]               req_col_index,
   input  logic signed [mme_pkg::VALUE_W-1:0]      req_elem_value,
   input  mme_pkg::dims_type                       dims,
   input  mme_pkg::queue_status_type               q_status,
   output logic                                    push,
   output mme_pkg::cmd_type                        push_cmd
);

   logic [mme_pkg::DIM_W-1:0] row_ext;
   logic [mme_pkg::DIM_W-1:0] col_ext;
   mme_pkg::op_type           op;

   assign row_ext = mme_pkg::DIM_W'(req_row_index);
   assign col_ext = mme_pkg::DIM_W'(req_col_index);

   // Classify the request against the current dimensions.
   always_comb begin
      unique case (req_type)
         mme_pkg::REQ_WRITE_A: begin
            op = (row_ext < dims.rows && col_ext < dims.inner) ?
                 mme_pkg::OP_WRITE_A : mme_pkg::OP_ERROR;
         end
         mme_pkg::REQ_WRITE_B: begin
            op = (row_ext < dims.inner && col_ext < dims.cols) ?
                 mme_pkg::OP_WRITE_B : mme_pkg::OP_ERROR;
         end
         mme_pkg::REQ_READ: begin
            op = (row_ext < dims.rows && col_ext < dims.cols) ?
                 mme_pkg::OP_READ : mme_pkg::OP_ERROR;
         end
         default: begin
            op = mme_pkg::OP_ERROR;
         end
      endcase
   end

   // A request is taken whenever the queue has room.
   assign busy  = q_status.full;
   assign push  = start && !q_status.full;

   assign push_cmd.op    = op;
   assign push_cmd.row   = req_row_index;
   assign push_cmd.col   = req_col_index;
   assign push_cmd.value = req_elem_value;

endmodule

// ===== design/mme_queue.sv =====
// Small command FIFO that decouples the front end from the back end.
module mme_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mme_pkg::cmd_type            push_cmd,
   input  logic                        pop,
   output mme_pkg::cmd_type            head_cmd,
   output mme_pkg::queue_status_type   q_status
);

   mme_pkg::cmd_type                   slot_ff [mme_pkg::QUEUE_DEPTH];
   logic [mme_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [mme_pkg::QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [mme_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [mme_pkg::QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [mme_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic [mme_pkg::QUEUE_CNT_W-1:0]    count_in;

   // Pointers wrap naturally because the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots carry no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == mme_pkg::QUEUE_CNT_W'(mme_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

// ===== design/mme_back.sv =====
// Back end: element stores and the shared multiply-accumulate sequencer.
module mme_back #(
   parameter int MAX_DIM = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mme_pkg::dims_type                        dims,
   input  mme_pkg::cmd_type                         head_cmd,
   input  mme_pkg::queue_status_type                q_status,
   output logic                                     pop,
   output logic                                     rsp_strobe,
   output logic signed [mme_pkg::PRODUCT_W-1:0]     rsp_product_value,
   output logic                                     rsp_status
);

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int K_W         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ACC_RAW_W   = mme_pkg::PROD_W + 1 + $clog2(MAX_DIM);
   localparam int ACC_W       = (ACC_RAW_W > 37) ? ACC_RAW_W : 37;
   localparam int SAT_PAD     = ACC_W - (mme_pkg::PRODUCT_W - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{SAT_PAD{1'b0}}, {(mme_pkg::PRODUCT_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{SAT_PAD{1'b1}}, {(mme_pkg::PRODUCT_W - 1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // Element stores, one read and one write port each.
   logic signed [mme_pkg::VALUE_W-1:0] a_mem [STORE_DEPTH];
   logic signed [mme_pkg::VALUE_W-1:0] b_mem [STORE_DEPTH];

   state_type                           state_ff, state_in;
   logic [mme_pkg::ROW_W-1:0]           row_ff, row_in;
   logic [mme_pkg::ROW_W-1:0]           col_ff, col_in;
   logic [K_W-1:0]                      k_ff, k_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic                                rd_last_ff, rd_last_in;
   logic                                mul_vld_ff;
   logic                                mul_last_ff;
   logic signed [mme_pkg::VALUE_W-1:0]  a_rd_ff;
   logic signed [mme_pkg::VALUE_W-1:0]  b_rd_ff;
   logic signed [mme_pkg::PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;
   logic signed [ACC_W-1:0]             sum;
   logic                                strobe_ff, strobe_in;
   logic signed [mme_pkg::PRODUCT_W-1:0] value_ff, value_in;
   logic                                status_ff, status_in;
   logic                                k_last;
   logic                                a_we;
   logic                                b_we;
   logic [ADDR_W-1:0]                   wr_addr;
   logic [ADDR_W-1:0]                   a_rd_addr;
   logic [ADDR_W-1:0]                   b_rd_addr;

   // Store addresses are row * MAX_DIM + column.
   assign wr_addr   = ADDR_W'(int'(head_cmd.row) * MAX_DIM + int'(head_cmd.col));
   assign a_rd_addr = ADDR_W'(int'(row_ff) * MAX_DIM + int'(k_ff));
   assign b_rd_addr = ADDR_W'(int'(k_ff) * MAX_DIM + int'(col_ff));

   assign pop    = (state_ff == ST_IDLE) && !q_status.empty;
   assign a_we   = pop && (head_cmd.op == mme_pkg::OP_WRITE_A);
   assign b_we   = pop && (head_cmd.op == mme_pkg::OP_WRITE_B);
   assign k_last = (int'(k_ff) + 1 == int'(dims.inner));

   // Accumulated sum including the product now leaving the multiplier.
   assign sum = acc_ff + {{(ACC_W - mme_pkg::PROD_W){prod_ff[mme_pkg::PROD_W-1]}}, prod_ff};

   // Store writes.
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[wr_addr] <= head_cmd.value;
      end
      if (b_we) begin
         b_mem[wr_addr] <= head_cmd.value;
      end
   end

   // Registered store reads and the product register.
   always_ff @(posedge clock) begin
      a_rd_ff <= a_mem[a_rd_addr];
      b_rd_ff <= b_mem[b_rd_addr];
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   // Sequencer: dispatch queued commands and step the dot product.
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      k_in       = k_ff;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      acc_in     = acc_ff;
      strobe_in  = 1'b0;
      value_in   = value_ff;
      status_in  = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (head_cmd.op)
                  mme_pkg::OP_WRITE_A, mme_pkg::OP_WRITE_B: begin
                     // The store write happens in this cycle; no response.
                  end
                  mme_pkg::OP_READ: begin
                     if (dims.inner == '0) begin
                        strobe_in = 1'b1;
                        value_in  = '0;
                        status_in = mme_pkg::STATUS_OK;
                     end else begin
                        row_in   = head_cmd.row;
                        col_in   = head_cmd.col;
                        k_in     = '0;
                        acc_in   = '0;
                        state_in = ST_ISSUE;
                     end
                  end
                  mme_pkg::OP_ERROR: begin
                     strobe_in = 1'b1;
                     value_in  = '0;
                     status_in = mme_pkg::STATUS_ERROR;
                  end
                  default: begin
                     strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            // One store read pair per cycle along the inner dimension.
            rd_vld_in  = 1'b1;
            rd_last_in = k_last;
            k_in       = k_ff + 1'b1;
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DRAIN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Accumulate each product as it leaves the multiplier.
      if (mul_vld_ff) begin
         acc_in = sum;
         if (mul_last_ff) begin
            strobe_in = 1'b1;
            status_in = mme_pkg::STATUS_OK;
            state_in  = ST_IDLE;
            if (sum > SAT_HI) begin
               value_in = mme_pkg::PRODUCT_W'(SAT_HI);
            end else if (sum < SAT_LO) begin
               value_in = mme_pkg::PRODUCT_W'(SAT_LO);
            end else begin
               value_in = mme_pkg::PRODUCT_W'(sum);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         rd_last_ff  <= 1'b0;
         mul_vld_ff  <= 1'b0;
         mul_last_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         rd_last_ff  <= rd_last_in;
         mul_vld_ff  <= rd_vld_ff;
         mul_last_ff <= rd_last_ff;
         strobe_ff   <= strobe_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_product_value = value_ff;
   assign rsp_status        = status_ff;

endmodule

// ===== design/matrix_multiply_engine.sv =====
// A write is stored when the back end pops it from the command queue; an error response
// is registered from its pop. The back end retires one write or error per cycle while
// commands are queued; a dot-product read uses the single multiply-accumulate unit and
// store read port, and no further command is popped until its response is registered.
// A two-entry command queue lets requests be taken while the back end works.
// Reset clears control state and sets all dimensions to 16; stores are not cleared.
module matrix_multiply_engine #(
   parameter int MAX_DIM = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [mme_pkg::REQ_W-1:0]                req_type,
   input  logic [mme_pkg::ROW_W-1:0]                req_row_index,
   input  logic [mme_pkg::ROW_W-1:0]                req_col_index,
   input  logic signed [mme_pkg::VALUE_W-1:0]       req_elem_value,
   output logic                                     rsp_strobe,
   output logic signed [mme_pkg::PRODUCT_W-1:0]     rsp_product_value,
   output logic                                     rsp_status,
   input  logic                                     csr_write_enable,
   input  logic [mme_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [mme_pkg::DIM_W-1:0]                csr_write_data
);

   logic [mme_pkg::DIM_W-1:0]   rows_a_ff;
   logic [mme_pkg::DIM_W-1:0]   inner_dim_ff;
   logic [mme_pkg::DIM_W-1:0]   cols_b_ff;
   mme_pkg::dims_type           dims;
   mme_pkg::queue_status_type   q_status;
   mme_pkg::cmd_type            push_cmd;
   mme_pkg::cmd_type            head_cmd;
   logic                        push;
   logic                        pop;

   // Dimension registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mme_pkg::DIM_RESET;
         inner_dim_ff <= mme_pkg::DIM_RESET;
         cols_b_ff    <= mme_pkg::DIM_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == mme_pkg::CSR_ROWS_A) begin
            rows_a_ff <= csr_write_data;
         end
         if (csr_index == mme_pkg::CSR_INNER_DIM) begin
            inner_dim_ff <= csr_write_data;
         end
         if (csr_index == mme_pkg::CSR_COLS_B) begin
            cols_b_ff <= csr_write_data;
         end
      end
   end

   // Dimensions above the store size act as the store size.
   assign dims.rows  = (int'(rows_a_ff) > MAX_DIM) ?
                       mme_pkg::DIM_W'(MAX_DIM) : rows_a_ff;
   assign dims.inner = (int'(inner_dim_ff) > MAX_DIM) ?
                       mme_pkg::DIM_W'(MAX_DIM) : inner_dim_ff;
   assign dims.cols  = (int'(cols_b_ff) > MAX_DIM) ?
                       mme_pkg::DIM_W'(MAX_DIM) : cols_b_ff;

   mme_front u_front (
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .dims           (dims),
      .q_status       (q_status),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   mme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   mme_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .dims              (dims),
      .head_cmd          (head_cmd),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_product_value (rsp_product_value),
      .rsp_status        (rsp_status)
   );

   // The queue is never full and empty at once.
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_status.empty)
      else $error("queue reports full and empty together");

   // An error response always carries a zero product.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == mme_pkg::STATUS_ERROR) |-> (rsp_product_value == '0))
      else $error("error response with nonzero product");

   // Reset leaves the engine ready and silent.
   assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("engine not idle after reset");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
